@@ hdl/assert_macros.svh @@
// Assertion macros shared by the page walker modules.
// No dependencies; each module that checks itself includes this file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge once reset has been released.
`define FLPW_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define FLPW_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/flpw_pkg.sv @@
// Shared types, codes and address masks for the four-level page walker.
// No dependencies; every walker module imports it.
`default_nettype none

package flpw_pkg;

  localparam int PHYS_BITS   = 36;
  localparam int INDEX_BITS  = 9;
  localparam int ADDR_BITS   = 52;
  localparam int VA_BITS     = 48;
  localparam int ENTRY_BITS  = 64;
  localparam int OFFSET_BITS = 30;

  localparam logic [ADDR_BITS-1:0] PHYS_MASK =
    (ADDR_BITS'(1) << PHYS_BITS) - ADDR_BITS'(1);
  localparam logic [ADDR_BITS-1:0] FRAME_4K_MASK = PHYS_MASK & ~ADDR_BITS'('hfff);
  localparam logic [ADDR_BITS-1:0] FRAME_2M_MASK = PHYS_MASK & ~ADDR_BITS'('h1fffff);

  // Entry flag positions.
  localparam int PRESENT_BIT = 0;
  localparam int LARGE_BIT   = 7;

  // Input item kinds.
  localparam logic KIND_REQUEST  = 1'b0;
  localparam logic KIND_RESPONSE = 1'b1;

  // Result kinds.
  localparam logic RESULT_READ = 1'b0;
  localparam logic RESULT_DONE = 1'b1;

  // Page size codes.
  localparam logic [1:0] PS_4K = 2'd0;
  localparam logic [1:0] PS_2M = 2'd1;
  localparam logic [1:0] PS_1G = 2'd2;

  typedef enum logic [1:0] {
    OP_READ,
    OP_DONE,
    OP_FAULT
  } op_t;

  // One queued result: the back end adds base and offset and formats it.
  typedef struct packed {
    op_t                    op;
    logic [ADDR_BITS-1:0]   base;
    logic [OFFSET_BITS-1:0] offset;
    logic [1:0]             size_code;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } push_t;

endpackage

`default_nettype wire

@@ hdl/four_level_page_walker_top.sv @@
// Top level of the four-level page walker: front end, command queue and
// back end. Depends on flpw_pkg, flpw_front, flpw_queue and flpw_back.
//
// Usage: one input channel (item_valid/item_ready) carries translate
// requests (kind 0: table_base, virtual_address) and memory responses
// (kind 1: entry_data, read_error). One output channel (result_valid/
// result_ready) carries entry read requests and finished translations.
// Each request yields a read of the top-level entry; each response during
// a walk yields the next read or the final address or fault. A response
// while no walk is active is taken and dropped.
// A command is written into the queue at its item beat and is moved into the
// back-end output register whenever that register is empty or being taken.
// Throughput: one item per cycle while item_ready is high; the front end
// updates the walk state at each item beat, so items may follow back to back.
// Reset clears the walk state and empties the queue and output register.
// When the receiver stalls, up to two results wait in the queue beside the
// held output beat, after which item_ready falls until a beat is taken.
`default_nettype none

module four_level_page_walker_top import flpw_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  item_valid,
  output logic                       item_ready,
  input  wire logic                  kind,
  input  wire logic [ADDR_BITS-1:0]  table_base,
  input  wire logic [VA_BITS-1:0]    virtual_address,
  input  wire logic [ENTRY_BITS-1:0] entry_data,
  input  wire logic                  read_error,
  output logic                       result_valid,
  input  wire logic                  result_ready,
  output logic                       result_kind,
  output logic [ADDR_BITS-1:0]       read_address,
  output logic [ADDR_BITS-1:0]       translated_address,
  output logic                       fault,
  output logic [1:0]                 size_code
);

  push_t queue_push;
  logic  queue_full;
  logic  queue_not_empty;
  logic  queue_pop;
  cmd_t  queue_head;

  flpw_front u_front (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_ready      (item_ready),
    .kind            (kind),
    .table_base      (table_base),
    .virtual_address (virtual_address),
    .entry_data      (entry_data),
    .read_error      (read_error),
    .queue_full      (queue_full),
    .queue_push      (queue_push)
  );

  flpw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .queue_push (queue_push),
    .full       (queue_full),
    .not_empty  (queue_not_empty),
    .pop        (queue_pop),
    .head       (queue_head)
  );

  flpw_back u_back (
    .clk                (clk),
    .rst                (rst),
    .not_empty          (queue_not_empty),
    .head               (queue_head),
    .pop                (queue_pop),
    .result_valid       (result_valid),
    .result_ready       (result_ready),
    .result_kind        (result_kind),
    .read_address       (read_address),
    .translated_address (translated_address),
    .fault              (fault),
    .size_code          (size_code)
  );

endmodule

`default_nettype wire

@@ hdl/flpw_front.sv @@
// Front end of the page walker: accepts items, keeps the walk state and
// classifies each item into a queued command. Depends on flpw_pkg.
`default_nettype none
`include "assert_macros.svh"

module flpw_front import flpw_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  item_valid,
  output logic                       item_ready,
  input  wire logic                  kind,
  input  wire logic [ADDR_BITS-1:0]  table_base,
  input  wire logic [VA_BITS-1:0]    virtual_address,
  input  wire logic [ENTRY_BITS-1:0] entry_data,
  input  wire logic                  read_error,
  input  wire logic                  queue_full,
  output push_t                      queue_push
);

  logic               busy, busy_next;
  logic [1:0]         level, level_next;
  logic [VA_BITS-1:0] held, held_next;

  logic [ENTRY_BITS-1:0] entry;
  logic [1:0]            next_level;
  logic [INDEX_BITS-1:0] next_index;
  logic [ADDR_BITS-1:0]  frame;

  assign item_ready = !queue_full;

  always_comb begin
    next_level = level + 2'd1;
    case (next_level)
      2'd1:    next_index = held[38:30];
      2'd2:    next_index = held[29:21];
      2'd3:    next_index = held[20:12];
      default: next_index = held[47:39];
    endcase
  end

  always_comb begin
    // A failed read counts as an all-zero entry, which is never present.
    entry = read_error ? '0 : entry_data;
    frame = entry[ADDR_BITS-1:0] & FRAME_4K_MASK;
    busy_next = busy;
    level_next = level;
    held_next = held;
    queue_push.push = 1'b0;
    queue_push.cmd.op = OP_READ;
    queue_push.cmd.base = '0;
    queue_push.cmd.offset = '0;
    queue_push.cmd.size_code = PS_4K;
    if (item_valid && item_ready) begin
      if (kind == KIND_REQUEST) begin
        // A new request abandons any walk in progress.
        busy_next = 1'b1;
        level_next = 2'd0;
        held_next = virtual_address;
        queue_push.push = 1'b1;
        queue_push.cmd.base = {table_base[ADDR_BITS-1:4], 4'b0};
        queue_push.cmd.offset = OFFSET_BITS'({virtual_address[47:39], 3'b0});
      end else if (busy) begin
        queue_push.push = 1'b1;
        if (!entry[PRESENT_BIT]) begin
          busy_next = 1'b0;
          level_next = 2'd0;
          queue_push.cmd.op = OP_FAULT;
        end else if (level == 2'd1 && entry[LARGE_BIT]) begin
          busy_next = 1'b0;
          level_next = 2'd0;
          queue_push.cmd.op = OP_DONE;
          queue_push.cmd.base = {entry[ADDR_BITS-1:30], 30'b0};
          queue_push.cmd.offset = held[29:0];
          queue_push.cmd.size_code = PS_1G;
        end else if (level == 2'd2 && entry[LARGE_BIT]) begin
          busy_next = 1'b0;
          level_next = 2'd0;
          queue_push.cmd.op = OP_DONE;
          queue_push.cmd.base = entry[ADDR_BITS-1:0] & FRAME_2M_MASK;
          queue_push.cmd.offset = OFFSET_BITS'(held[20:0]);
          queue_push.cmd.size_code = PS_2M;
        end else if (level == 2'd3) begin
          busy_next = 1'b0;
          level_next = 2'd0;
          if (frame == '0) begin
            queue_push.cmd.op = OP_FAULT;
          end else begin
            queue_push.cmd.op = OP_DONE;
            queue_push.cmd.base = frame;
            queue_push.cmd.offset = OFFSET_BITS'(held[11:0]);
          end
        end else begin
          level_next = next_level;
          queue_push.cmd.base = frame;
          queue_push.cmd.offset = OFFSET_BITS'({next_index, 3'b0});
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      level <= 2'd0;
      held <= '0;
    end else begin
      busy <= busy_next;
      level <= level_next;
      held <= held_next;
    end
  end

  `FLPW_ASSERT(a_idle_level_zero, clk, rst, !busy |-> level == 2'd0, "walk level set while idle")
  `FLPW_ASSERT(a_no_push_when_full, clk, rst, queue_full |-> !queue_push.push, "push into full queue")

endmodule

`default_nettype wire

@@ hdl/flpw_queue.sv @@
// Two-entry command queue between the walker front and back ends.
// Depends on flpw_pkg for the command type.
`default_nettype none
`include "assert_macros.svh"

module flpw_queue import flpw_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire push_t queue_push,
  output logic       full,
  output logic       not_empty,
  input  wire logic  pop,
  output cmd_t       head
);

  cmd_t       slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       do_push, do_pop;

  assign full = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign do_push = queue_push.push && !full;
  assign do_pop = pop && not_empty;
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= queue_push.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  `FLPW_ASSERT(a_count_range, clk, rst, count != 2'd3, "queue count out of range")

endmodule

`default_nettype wire

@@ hdl/flpw_back.sv @@
// Back end of the page walker: takes queued commands, forms the address
// and holds the result in the output register. Depends on flpw_pkg.
`default_nettype none
`include "assert_macros.svh"

module flpw_back import flpw_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 not_empty,
  input  wire cmd_t                 head,
  output logic                      pop,
  output logic                      result_valid,
  input  wire logic                 result_ready,
  output logic                      result_kind,
  output logic [ADDR_BITS-1:0]      read_address,
  output logic [ADDR_BITS-1:0]      translated_address,
  output logic                      fault,
  output logic [1:0]                size_code
);

  logic [ADDR_BITS-1:0] sum;

  assign pop = not_empty && (!result_valid || result_ready);
  assign sum = head.base + ADDR_BITS'(head.offset);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      case (head.op)
        OP_READ: begin
          result_kind <= RESULT_READ;
          read_address <= sum;
          translated_address <= '0;
          fault <= 1'b0;
          size_code <= PS_4K;
        end
        OP_DONE: begin
          result_kind <= RESULT_DONE;
          read_address <= '0;
          translated_address <= sum;
          fault <= 1'b0;
          size_code <= head.size_code;
        end
        default: begin
          result_kind <= RESULT_DONE;
          read_address <= '0;
          translated_address <= '0;
          fault <= 1'b1;
          size_code <= PS_4K;
        end
      endcase
    end
  end

  `FLPW_ASSERT(a_fault_clean, clk, rst,
    result_valid && fault |-> result_kind == RESULT_DONE && translated_address == '0,
    "fault result carries an address")

endmodule

`default_nettype wire

@@ tb/four_level_page_walker_top_tb.sv @@
// Self-checking testbench for four_level_page_walker_top: directed and random
// translate walks against a walk predictor in a small scoreboard class.
// Depends on flpw_pkg and the walker RTL only.
`default_nettype none

module four_level_page_walker_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import flpw_pkg::*;

  // Frame fields of a table entry, from the physical address width.
  localparam logic [ADDR_BITS-1:0] PHYS_FIELD  = (ADDR_BITS'(1) << PHYS_BITS) - ADDR_BITS'(1);
  localparam logic [ADDR_BITS-1:0] TABLE_FRAME = PHYS_FIELD & ~ADDR_BITS'(32'hfff);
  localparam logic [ADDR_BITS-1:0] FRAME_2M    = PHYS_FIELD & ~ADDR_BITS'(32'h1fffff);

  typedef struct packed {
    logic                 kind;
    logic [ADDR_BITS-1:0] read_addr;
    logic [ADDR_BITS-1:0] phys_addr;
    logic                 fault;
    logic [1:0]           size;
  } walk_result_t;

  class walk_tracker;
    bit                 busy;
    int                 level;
    logic [VA_BITS-1:0] held_va;
    walk_result_t       pending_results[$];
    int                 failures;

    function new();
      busy = 0;
      level = 0;
      held_va = '0;
      failures = 0;
    endfunction

    function logic [INDEX_BITS-1:0] va_index(int lvl);
      return held_va[12 + INDEX_BITS * (3 - lvl) +: INDEX_BITS];
    endfunction

    function void push_read(logic [ADDR_BITS-1:0] addr);
      walk_result_t r;
      r = '{RESULT_READ, addr, '0, 1'b0, PS_4K};
      pending_results.push_back(r);
    endfunction

    function void push_done(logic [ADDR_BITS-1:0] pa, logic flt, logic [1:0] ps);
      walk_result_t r;
      busy = 0;
      level = 0;
      if (flt) r = '{RESULT_DONE, '0, '0, 1'b1, PS_4K};
      else r = '{RESULT_DONE, '0, pa, 1'b0, ps};
      pending_results.push_back(r);
    endfunction

    // Advances the walk by one accepted input beat.
    function void take_item(logic k, logic [ADDR_BITS-1:0] tb, logic [VA_BITS-1:0] va,
                            logic [ENTRY_BITS-1:0] ed, logic err);
      logic [ENTRY_BITS-1:0] e;
      logic [ADDR_BITS-1:0]  frame;
      if (k == KIND_REQUEST) begin
        held_va = va;
        busy = 1;
        level = 0;
        push_read((tb & ~ADDR_BITS'(32'hf)) + ADDR_BITS'(8 * va_index(0)));
        return;
      end
      if (!busy) return;
      e = err ? '0 : ed;
      frame = e[ADDR_BITS-1:0] & TABLE_FRAME;
      if (!e[PRESENT_BIT]) begin
        push_done('0, 1'b1, PS_4K);
      end else if (level == 1 && e[LARGE_BIT]) begin
        push_done({e[ADDR_BITS-1:30], held_va[29:0]}, 1'b0, PS_1G);
      end else if (level == 2 && e[LARGE_BIT]) begin
        push_done((e[ADDR_BITS-1:0] & FRAME_2M) + ADDR_BITS'(held_va[20:0]), 1'b0, PS_2M);
      end else if (level == 3) begin
        if (frame == '0) push_done('0, 1'b1, PS_4K);
        else push_done(frame + ADDR_BITS'(held_va[11:0]), 1'b0, PS_4K);
      end else begin
        level = level + 1;
        push_read(frame + ADDR_BITS'(8 * va_index(level)));
      end
    endfunction

    function void report(string what, walk_result_t want, walk_result_t got);
      failures++;
      if (failures <= 10)
        $display({"%s: expected kind %0d read %h phys %h fault %0d size %0d, ",
                  "got kind %0d read %h phys %h fault %0d size %0d"},
                 what, want.kind, want.read_addr, want.phys_addr, want.fault, want.size,
                 got.kind, got.read_addr, got.phys_addr, got.fault, got.size);
    endfunction

    function void check_result(logic k, logic [ADDR_BITS-1:0] ra, logic [ADDR_BITS-1:0] pa,
                               logic flt, logic [1:0] ps);
      walk_result_t got;
      walk_result_t want;
      got = '{k, ra, pa, flt, ps};
      if (pending_results.size() == 0) begin
        report("result beat with nothing outstanding", '0, got);
        return;
      end
      want = pending_results.pop_front();
      if (got !== want) report("result mismatch", want, got);
    endfunction

    function void flush_leftovers();
      walk_result_t want;
      while (pending_results.size() != 0) begin
        want = pending_results.pop_front();
        failures++;
        if (failures <= 10)
          $display("missing result: expected kind %0d read %h phys %h fault %0d size %0d",
                   want.kind, want.read_addr, want.phys_addr, want.fault, want.size);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  item_valid;
  logic                  item_ready;
  logic                  kind;
  logic [ADDR_BITS-1:0]  table_base;
  logic [VA_BITS-1:0]    virtual_address;
  logic [ENTRY_BITS-1:0] entry_data;
  logic                  read_error;
  logic                  result_valid;
  logic                  result_ready;
  logic                  result_kind;
  logic [ADDR_BITS-1:0]  read_address;
  logic [ADDR_BITS-1:0]  translated_address;
  logic                  fault;
  logic [1:0]            size_code;

  walk_tracker sb;
  bit          tx_steady;
  bit          rx_steady;

  four_level_page_walker_top u_dut (
    .clk                (clk),
    .rst                (rst),
    .item_valid         (item_valid),
    .item_ready         (item_ready),
    .kind               (kind),
    .table_base         (table_base),
    .virtual_address    (virtual_address),
    .entry_data         (entry_data),
    .read_error         (read_error),
    .result_valid       (result_valid),
    .result_ready       (result_ready),
    .result_kind        (result_kind),
    .read_address       (read_address),
    .translated_address (translated_address),
    .fault              (fault),
    .size_code          (size_code)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && item_valid && item_ready)
      sb.take_item(kind, table_base, virtual_address, entry_data, read_error);
    if (!rst && result_valid && result_ready)
      sb.check_result(result_kind, read_address, translated_address, fault, size_code);
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly random, with all-zero and all-one values now and then.
  function automatic logic [63:0] field_value();
    case ($urandom_range(0, 7))
      0: return '1;
      1: return '0;
      default: return rand64();
    endcase
  endfunction

  // A present entry that lets the walk go on below the given level (a page at level 3).
  function automatic logic [ENTRY_BITS-1:0] table_entry(int lvl);
    logic [ENTRY_BITS-1:0] e;
    e = rand64();
    e[PRESENT_BIT] = 1'b1;
    if (lvl == 1 || lvl == 2) e[LARGE_BIT] = 1'b0;
    if (lvl == 3 && e[PHYS_BITS-1:12] == '0) e[12] = 1'b1;
    return e;
  endfunction

  // Offers one beat after a random gap (none when tx_steady is set) and returns at the edge that takes it.
  task automatic drive_item(input logic k, input logic [ADDR_BITS-1:0] tb,
                            input logic [VA_BITS-1:0] va, input logic [ENTRY_BITS-1:0] ed,
                            input logic err);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid      <= 1'b1;
    kind            <= k;
    table_base      <= tb;
    virtual_address <= va;
    entry_data      <= ed;
    read_error      <= err;
    do @(posedge clk); while (!item_ready);
  endtask

  task automatic drive_response(input logic [ENTRY_BITS-1:0] ed, input logic err);
    drive_item(KIND_RESPONSE, ADDR_BITS'(rand64()), VA_BITS'(rand64()), ed, err);
  endtask

  task automatic drive_request(input logic [ADDR_BITS-1:0] tb, input logic [VA_BITS-1:0] va);
    drive_item(KIND_REQUEST, tb, va, rand64(), 1'(rand64()));
  endtask

  // One walk with random content; most run to a page or a fault, a few are
  // abandoned so that the next request cuts in.
  task automatic random_walk(inout int count);
    logic [ENTRY_BITS-1:0] e;
    logic                  err;
    int                    lvl;
    int                    pick;
    bit                    done;
    tx_steady = ($urandom_range(0, 3) == 0);
    drive_request(ADDR_BITS'(field_value()), VA_BITS'(field_value()));
    count++;
    done = 0;
    for (lvl = 0; lvl < 4 && !done; lvl++) begin
      pick = $urandom_range(0, 99);
      e = table_entry(lvl);
      err = 1'b0;
      if (pick < 5) return;
      if (pick < 12) begin
        e[PRESENT_BIT] = 1'b0;
        done = 1;
      end else if (pick < 17) begin
        e = rand64();
        err = 1'b1;
        done = 1;
      end else if ((lvl == 1 || lvl == 2) && pick < 32) begin
        e[LARGE_BIT] = 1'b1;
        done = 1;
      end else if (lvl == 3) begin
        if (pick < 27) e[PHYS_BITS-1:12] = '0;
        done = 1;
      end
      drive_response(e, err);
      count++;
    end
    // A stray response after the walk has ended is dropped by the block.
    if ($urandom_range(0, 9) == 0) drive_response(rand64(), 1'(rand64()));
  endtask

  // Receiver: random stalls, stretches with none, and one long hold-off that
  // backs the walker up until it stops taking input beats.
  initial begin
    int gap;
    int taken;
    taken = 0;
    result_ready = 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (taken % 40 == 0) rx_steady = ($urandom_range(0, 3) == 0);
      if (taken == 150) gap = 400;
      else if (rx_steady) gap = 0;
      else gap = $urandom_range(0, 16);
      if (gap > 0) begin
        result_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
      taken++;
    end
  end

  initial begin
    #3ms;
    $display("four_level_page_walker_top regression: fail");
    $finish;
  end

  initial begin
    int walk_items;
    int waited;
    sb = new();
    walk_items = 0;
    tx_steady = 0;
    item_valid = 1'b0;
    kind = KIND_REQUEST;
    table_base = '0;
    virtual_address = '0;
    entry_data = '0;
    read_error = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Nothing to continue yet, so this response is dropped.
    drive_item(KIND_RESPONSE, '1, '1, '1, 1'b0);
    // All-ones base and address make the top-level read address wrap.
    drive_item(KIND_REQUEST, '1, '1, '1, 1'b1);
    drive_item(KIND_RESPONSE, '0, '0, '1, 1'b1);
    drive_item(KIND_REQUEST, '0, '0, '0, 1'b0);
    // The large bit means nothing at the top level, but gives a 1GB page next.
    drive_item(KIND_RESPONSE, '0, '0, '1, 1'b0);
    drive_item(KIND_RESPONSE, '0, '0, '1, 1'b0);
    drive_request(ADDR_BITS'(rand64()), VA_BITS'(rand64()));
    drive_response(table_entry(0), 1'b0);
    drive_response(table_entry(1), 1'b0);
    drive_response('1, 1'b0);
    drive_request(ADDR_BITS'(rand64()), VA_BITS'(rand64()));
    drive_response(~ENTRY_BITS'(1), 1'b0);
    drive_request(ADDR_BITS'(rand64()), '1);
    drive_response(table_entry(0), 1'b0);
    drive_response(table_entry(1), 1'b0);
    drive_response(table_entry(2), 1'b0);
    drive_response('1, 1'b0);
    drive_request(ADDR_BITS'(rand64()), VA_BITS'(rand64()));
    drive_response(table_entry(0), 1'b0);
    // A new request in the middle of a walk abandons it.
    drive_request(ADDR_BITS'(rand64()), VA_BITS'(rand64()));
    drive_response(table_entry(0), 1'b0);
    drive_response(table_entry(1), 1'b0);
    drive_response(table_entry(2), 1'b0);
    drive_response(ENTRY_BITS'(1), 1'b0);
    drive_response(rand64(), 1'b0);

    while (walk_items < 600) random_walk(walk_items);
    item_valid <= 1'b0;

    waited = 0;
    while (sb.pending_results.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    // Let any late beat show up before the books are closed.
    repeat (10) @(posedge clk);
    sb.flush_leftovers();

    if (sb.failures == 0)
      $display("four_level_page_walker_top regression: pass");
    else
      $display("four_level_page_walker_top regression: fail");
    $finish;
  end

endmodule

`default_nettype wire

@@ four_level_page_walker_top.f @@
+incdir+hdl
hdl/flpw_pkg.sv
hdl/flpw_front.sv
hdl/flpw_queue.sv
hdl/flpw_back.sv
hdl/four_level_page_walker_top.sv
tb/four_level_page_walker_top_tb.sv
